// ----- rtl/u16u8_pkg.sv -----
package u16u8_pkg;

  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  localparam logic [15:0] SurHighFirst = 16'hD800;
  localparam logic [15:0] SurHighLast  = 16'hDBFF;
  localparam logic [15:0] SurLowFirst  = 16'hDC00;
  localparam logic [15:0] SurLowLast   = 16'hDFFF;

  localparam logic [20:0] Limit1Byte   = 21'h00080;
  localparam logic [20:0] Limit2Byte   = 21'h00800;
  localparam logic [20:0] Limit3Byte   = 21'h10000;
  localparam logic [20:0] SuppBase     = 21'h10000;

  localparam logic [7:0]  Lead2        = 8'hC0;
  localparam logic [7:0]  Lead3        = 8'hE0;
  localparam logic [7:0]  Lead4        = 8'hF0;
  localparam logic [7:0]  ContMark     = 8'h80;
  localparam logic [7:0]  ContMask     = 8'h3F;

  // One encoded code point: up to four bytes, b[0] goes out first.
  typedef struct packed {
    logic [3:0][7:0] b;
    logic [2:0]      len;
  } seq_t;

  // Work handed from the front end to the byte sequencer. s0 is never empty.
  typedef struct packed {
    seq_t s0;
    seq_t s1;
    logic last;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [7:0] cont_byte(input logic [5:0] bits6);
    return ContMark | ({2'b00, bits6} & ContMask);
  endfunction

  function automatic seq_t encode_point(input logic [20:0] cp);
    seq_t s;
    s = '0;
    if (cp < Limit1Byte) begin
      s.b[0] = cp[7:0];
      s.len  = 3'd1;
    end else if (cp < Limit2Byte) begin
      s.b[0] = Lead2 | {3'b000, cp[10:6]};
      s.b[1] = cont_byte(cp[5:0]);
      s.len  = 3'd2;
    end else if (cp < Limit3Byte) begin
      s.b[0] = Lead3 | {4'b0000, cp[15:12]};
      s.b[1] = cont_byte(cp[11:6]);
      s.b[2] = cont_byte(cp[5:0]);
      s.len  = 3'd3;
    end else begin
      s.b[0] = Lead4 | {5'b00000, cp[20:18]};
      s.b[1] = cont_byte(cp[17:12]);
      s.b[2] = cont_byte(cp[11:6]);
      s.b[3] = cont_byte(cp[5:0]);
      s.len  = 3'd4;
    end
    return s;
  endfunction

endpackage

// ----- rtl/u16u8_if.sv -----
interface u16u8_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        last_unit;

  modport source (output valid, code_unit, last_unit, input ready);
  modport sink   (input valid, code_unit, last_unit, output ready);
endinterface

interface u16u8_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       text_end;

  modport source (output valid, out_byte, run_last, text_end, input ready);
  modport sink   (input valid, out_byte, run_last, text_end, output ready);
endinterface

// ----- rtl/u16u8_front.sv -----
module u16u8_front (
  input  logic                clk,
  input  logic                rst,
  u16u8_unit_if.sink          units,
  input  u16u8_pkg::q_status_t q_stat,
  output logic                push,
  output u16u8_pkg::job_t     push_job
);
  import u16u8_pkg::*;

  logic       held_valid;
  logic [9:0] held_high_bits;
  logic       held_valid_next;
  logic [9:0] held_high_bits_next;
  logic       accept;
  logic       is_high;
  logic       is_low;
  logic       has_job;
  logic [20:0] pair_cp;

  assign units.ready = !q_stat.full;
  assign accept      = units.valid && units.ready;

  assign is_high = units.code_unit >= SurHighFirst && units.code_unit <= SurHighLast;
  assign is_low  = units.code_unit >= SurLowFirst  && units.code_unit <= SurLowLast;
  assign pair_cp = SuppBase + {1'b0, held_high_bits, units.code_unit[9:0]};

  always_comb begin
    push_job            = '0;
    push_job.last       = units.last_unit;
    has_job             = 1'b1;
    held_valid_next     = 1'b0;
    held_high_bits_next = '0;
    if (held_valid) begin
      if (is_low) begin
        push_job.s0 = encode_point(pair_cp);
      end else begin
        // orphaned high surrogate goes out on its own, then the new unit unless that is a high surrogate to hold
        push_job.s0 = encode_point({5'b00000, SurHighFirst | {6'b000000, held_high_bits}});
        if (is_high && !units.last_unit) begin
          held_valid_next     = 1'b1;
          held_high_bits_next = units.code_unit[9:0];
        end else begin
          push_job.s1 = encode_point({5'b00000, units.code_unit});
        end
      end
    end else if (is_high && !units.last_unit) begin
      has_job             = 1'b0;
      held_valid_next     = 1'b1;
      held_high_bits_next = units.code_unit[9:0];
    end else begin
      push_job.s0 = encode_point({5'b00000, units.code_unit});
    end
  end

  assign push = accept && has_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid     <= 1'b0;
      held_high_bits <= '0;
    end else if (accept) begin
      held_valid     <= held_valid_next;
      held_high_bits <= held_high_bits_next;
    end
  end

endmodule

// ----- rtl/u16u8_queue.sv -----
module u16u8_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  u16u8_pkg::job_t      push_job,
  input  logic                 pop,
  output u16u8_pkg::job_t      head,
  output u16u8_pkg::q_status_t q_stat
);
  import u16u8_pkg::*;

  job_t             entries [QueueDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] count;

  assign head         = entries[rd_ptr];
  assign q_stat.full  = count == QCntW'(QueueDepth);
  assign q_stat.empty = count == '0;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/u16u8_back.sv -----
module u16u8_back (
  input  logic                 clk,
  input  logic                 rst,
  input  u16u8_pkg::job_t      head,
  input  u16u8_pkg::q_status_t q_stat,
  output logic                 pop,
  u16u8_byte_if.source         bytes
);
  import u16u8_pkg::*;

  logic       sel;
  logic [1:0] idx;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       run_last;
  logic       text_end;
  logic       load;
  seq_t       cur;
  logic       seq_end;
  logic       job_end;

  assign cur     = sel ? head.s1 : head.s0;
  assign seq_end = ({1'b0, idx} + 3'd1) == cur.len;
  assign job_end = seq_end && (sel || head.s1.len == '0);
  assign load    = !q_stat.empty && (!out_valid || bytes.ready);
  assign pop     = load && job_end;

  assign bytes.valid    = out_valid;
  assign bytes.out_byte = out_byte;
  assign bytes.run_last = run_last;
  assign bytes.text_end = text_end;

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= cur.b[idx];
      run_last <= job_end;
      text_end <= job_end && head.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sel       <= 1'b0;
      idx       <= '0;
    end else begin
      out_valid <= load || (out_valid && !bytes.ready);
      if (load) begin
        if (job_end) begin
          sel <= 1'b0;
          idx <= '0;
        end else if (seq_end) begin
          sel <= 1'b1;
          idx <= '0;
        end else begin
          idx <= idx + 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/utf16_to_utf8_encoder.sv -----
// Path: a unit's job goes into the job queue, its bytes then into the output register.
// Throughput: one output byte per cycle while bytes.ready holds and the queue has a job;
// a unit yields 1 to 6 bytes, and a held high surrogate yields none.
// The byte sequencer emits these bytes from a 2-entry job queue.
// Reset (rst, synchronous, active high) clears the held surrogate, queue and output.
module utf16_to_utf8_encoder (
  input  logic         clk,
  input  logic         rst,
  u16u8_unit_if.sink   units,
  u16u8_byte_if.source bytes
);
  import u16u8_pkg::*;

  logic      push;
  logic      pop;
  job_t      push_job;
  job_t      head;
  q_status_t q_stat;

  u16u8_front u_front (
    .clk      (clk),
    .rst      (rst),
    .units    (units),
    .q_stat   (q_stat),
    .push     (push),
    .push_job (push_job)
  );

  u16u8_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  u16u8_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .bytes  (bytes)
  );

endmodule

// ----- rtl/u16u8_checker.sv -----
module u16u8_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       run_last,
  input logic       text_end
);

  // end of text is always the end of a request's bytes
  a_end_is_run_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (run_last || !text_end))
    else $error("text_end without run_last");

  // the rest of a multi-byte run is ready right after each byte is taken
  a_run_no_gap: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !run_last) |=> out_valid)
    else $error("gap inside a byte run");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_byte) && $stable(run_last)
                                   && $stable(text_end)))
    else $error("stalled output changed");

endmodule

bind utf16_to_utf8_encoder u16u8_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (bytes.valid),
  .out_ready (bytes.ready),
  .out_byte  (bytes.out_byte),
  .run_last  (bytes.run_last),
  .text_end  (bytes.text_end)
);
